@@ rtl/msfc_pkg.sv @@
// shared types and constants of the membrane solute face coefficient block
`default_nettype none

package msfc_pkg;

  localparam int FracBits = 24;
  localparam int Lanes    = 4;
  localparam int NumW     = 96;
  localparam int RemW     = 64;
  localparam int QuoW     = 32;
  localparam int DivSteps = QuoW;

  localparam logic [24:0] OneQ   = 25'(64'd1 << FracBits);
  localparam logic [31:0] SatPos = 32'h7fff_ffff;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    RegRejection     = 2'd0,
    RegDiffMin       = 2'd1,
    RegDiffCoeff     = 2'd2,
    RegDiffConcCoeff = 2'd3
  } cfg_reg_e;

  typedef logic [NumW-1:0] num_t;
  typedef logic [RemW-1:0] rem_t;
  typedef logic [QuoW-1:0] quo_t;

  typedef struct packed {
    logic [24:0]        rejection;
    logic [30:0]        diff_min;
    logic [30:0]        diff_coeff;
    logic signed [31:0] diff_conc_coeff;
  } cfg_t;

  typedef struct packed {
    logic        inflow;
    logic        unres;
    logic [30:0] cell_conc;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/msfc_front.sv @@
// front pipeline: velocity magnitude, products, diffusivity, divisor and numerators
`default_nettype none

module msfc_front (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire msfc_pkg::cfg_t                            cfg_i,
  input  wire logic                                      valid_i,
  input  wire logic signed [31:0]                        normal_velocity_i,
  input  wire logic [30:0]                               cell_spacing_i,
  input  wire logic [30:0]                               face_conc_i,
  input  wire logic [30:0]                               opposite_conc_i,
  input  wire logic [30:0]                               cell_conc_i,
  output logic                                           valid_o,
  output msfc_pkg::side_t                                side_o,
  output msfc_pkg::rem_t                                 den_o,
  output msfc_pkg::num_t [msfc_pkg::Lanes-1:0]           num_o
);

  // stage a
  logic        a_valid_q;
  logic        a_inflow_q;
  logic [31:0] a_mag_q;
  logic [30:0] a_delta_q, a_fc_q, a_oc_q, a_cc_q;
  logic [31:0] mag_raw, mag_d;
  logic [30:0] delta_d;

  assign mag_raw = normal_velocity_i[31] ? (32'd0 - 32'(normal_velocity_i))
                                         : 32'(normal_velocity_i);
  assign mag_d   = (mag_raw == 32'd0) ? 32'd1 : mag_raw;
  assign delta_d = (cell_spacing_i == 31'd0) ? 31'd1 : cell_spacing_i;

  always_ff @(posedge clk_i) begin
    a_inflow_q <= normal_velocity_i[31];
    a_mag_q    <= mag_d;
    a_delta_q  <= delta_d;
    a_fc_q     <= face_conc_i;
    a_oc_q     <= opposite_conc_i;
    a_cc_q     <= cell_conc_i;
  end

  // stage b
  logic        b_valid_q, b_inflow_q;
  logic [31:0] b_mag_q, b_ur_q;
  logic [30:0] b_delta_q, b_cc_q, b_kf_q;
  logic [62:0] b_s_q;
  logic signed [62:0] b_mc_q;
  logic [24:0] r_eff, one_minus_r;
  logic [56:0] ur_prod;
  logic [62:0] s_prod;
  logic [55:0] kf_prod;
  logic signed [62:0] dcc_x, fc_x, mc_prod;

  assign r_eff       = (cfg_i.rejection > msfc_pkg::OneQ) ? msfc_pkg::OneQ : cfg_i.rejection;
  assign one_minus_r = msfc_pkg::OneQ - r_eff;
  assign ur_prod     = 57'(a_mag_q) * 57'(r_eff);
  assign s_prod      = 63'(a_mag_q) * 63'(a_delta_q);
  assign kf_prod     = 56'(one_minus_r) * 56'(a_oc_q);
  assign dcc_x       = 63'($signed(cfg_i.diff_conc_coeff));
  assign fc_x        = $signed(63'(a_fc_q));
  assign mc_prod     = dcc_x * fc_x;

  always_ff @(posedge clk_i) begin
    b_inflow_q <= a_inflow_q;
    b_mag_q    <= a_mag_q;
    b_delta_q  <= a_delta_q;
    b_cc_q     <= a_cc_q;
    b_ur_q     <= ur_prod[msfc_pkg::FracBits +: 32];
    b_s_q      <= s_prod;
    b_kf_q     <= kf_prod[msfc_pkg::FracBits +: 31];
    b_mc_q     <= mc_prod;
  end

  // stage c
  logic        c_valid_q, c_inflow_q, c_tpos_q;
  logic [31:0] c_mag_q, c_ur_q;
  logic [30:0] c_cc_q;
  logic [39:0] c_t_q;
  logic [62:0] c_urd_q, c_kfs_hi_q, c_kfm_q, c_s_q;
  logic [61:0] c_kfs_lo_q;
  logic signed [62:0] fl;
  logic [63:0] t_full;

  assign fl     = b_mc_q >>> msfc_pkg::FracBits;
  assign t_full = 64'(msfc_pkg::OneQ) - 64'(fl);

  always_ff @(posedge clk_i) begin
    c_inflow_q <= b_inflow_q;
    c_mag_q    <= b_mag_q;
    c_ur_q     <= b_ur_q;
    c_cc_q     <= b_cc_q;
    c_s_q      <= b_s_q;
    c_t_q      <= t_full[39:0];
    c_tpos_q   <= !t_full[63] && (t_full != 64'd0);
    c_urd_q    <= 63'(b_ur_q) * 63'(b_delta_q);
    c_kfs_lo_q <= 62'(b_kf_q) * 62'(b_s_q[30:0]);
    c_kfs_hi_q <= 63'(b_kf_q) * 63'(b_s_q[62:31]);
    c_kfm_q    <= 63'(b_kf_q) * 63'(b_mag_q);
  end

  // stage d
  logic        d_valid_q, d_inflow_q, d_tpos_q;
  logic [31:0] d_mag_q, d_ur_q;
  logic [30:0] d_cc_q;
  logic [50:0] d_plo_q, d_phi_q;
  logic [62:0] d_urd_q, d_kfm_q, d_s_q;
  logic [93:0] d_kfs_q;

  always_ff @(posedge clk_i) begin
    d_inflow_q <= c_inflow_q;
    d_tpos_q   <= c_tpos_q;
    d_mag_q    <= c_mag_q;
    d_ur_q     <= c_ur_q;
    d_cc_q     <= c_cc_q;
    d_urd_q    <= c_urd_q;
    d_kfm_q    <= c_kfm_q;
    d_s_q      <= c_s_q;
    d_plo_q    <= 51'(cfg_i.diff_coeff) * 51'(c_t_q[19:0]);
    d_phi_q    <= 51'(cfg_i.diff_coeff) * 51'(c_t_q[39:20]);
    d_kfs_q    <= (94'(c_kfs_hi_q) << 31) + 94'(c_kfs_lo_q);
  end

  // stage e
  logic        e_valid_q, e_inflow_q;
  logic [31:0] e_mag_q, e_ur_q;
  logic [30:0] e_cc_q, e_d_q;
  logic [62:0] e_urd_q, e_kfm_q, e_s_q;
  logic [93:0] e_kfs_q;
  logic [70:0] p_full, p_sh;
  logic [30:0] p_sat, diff_d;

  assign p_full = (71'(d_phi_q) << 20) + 71'(d_plo_q);
  assign p_sh   = p_full >> msfc_pkg::FracBits;
  assign p_sat  = (p_sh > 71'(msfc_pkg::SatPos)) ? 31'h7fff_ffff : p_sh[30:0];
  assign diff_d = !d_tpos_q ? cfg_i.diff_min
                : ((p_sat > cfg_i.diff_min) ? p_sat : cfg_i.diff_min);

  always_ff @(posedge clk_i) begin
    e_inflow_q <= d_inflow_q;
    e_mag_q    <= d_mag_q;
    e_ur_q     <= d_ur_q;
    e_cc_q     <= d_cc_q;
    e_urd_q    <= d_urd_q;
    e_kfm_q    <= d_kfm_q;
    e_s_q      <= d_s_q;
    e_kfs_q    <= d_kfs_q;
    e_d_q      <= diff_d;
  end

  // stage f: divisor, numerators, layer check
  logic        f_valid_q;
  msfc_pkg::side_t f_side_q;
  msfc_pkg::rem_t  f_den_q;
  msfc_pkg::num_t [msfc_pkg::Lanes-1:0] f_num_q;
  logic [63:0] dq;
  logic [64:0] up_diff;
  logic        unres_d;
  logic [31:0] lane1_val;

  assign dq        = 64'(e_d_q) << msfc_pkg::FracBits;
  assign up_diff   = {1'b0, dq} - 65'(e_urd_q);
  assign unres_d   = !e_inflow_q && (up_diff[64] || (up_diff == 65'd0));
  assign lane1_val = e_inflow_q ? e_mag_q : e_ur_q;

  always_ff @(posedge clk_i) begin
    f_side_q.inflow    <= e_inflow_q;
    f_side_q.unres     <= unres_d;
    f_side_q.cell_conc <= e_cc_q;
    f_den_q <= e_inflow_q ? (dq + 64'(e_s_q)) : (unres_d ? 64'd1 : up_diff[63:0]);
    f_num_q[0] <= msfc_pkg::NumW'(e_d_q) << (2 * msfc_pkg::FracBits);
    f_num_q[1] <= msfc_pkg::NumW'(lane1_val) << (2 * msfc_pkg::FracBits);
    f_num_q[2] <= e_inflow_q ? msfc_pkg::NumW'(e_kfs_q) : '0;
    f_num_q[3] <= e_inflow_q ? (msfc_pkg::NumW'(e_kfm_q) << msfc_pkg::FracBits) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
    end
  end

  assign valid_o = f_valid_q;
  assign side_o  = f_side_q;
  assign den_o   = f_den_q;
  assign num_o   = f_num_q;

endmodule

`default_nettype wire

@@ rtl/msfc_div.sv @@
// pipelined restoring divider, four numerator lanes over one shared divisor
`default_nettype none

module msfc_div (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  input  wire msfc_pkg::side_t                           side_i,
  input  wire msfc_pkg::rem_t                            den_i,
  input  wire msfc_pkg::num_t [msfc_pkg::Lanes-1:0]      num_i,
  output logic                                           valid_o,
  output msfc_pkg::side_t                                side_o,
  output msfc_pkg::quo_t [msfc_pkg::Lanes-1:0]           quo_o,
  output logic [msfc_pkg::Lanes-1:0]                     sat_o
);

  localparam int Steps = msfc_pkg::DivSteps;
  localparam int RemW  = msfc_pkg::RemW;
  localparam int QuoW  = msfc_pkg::QuoW;

  logic            vld_q  [Steps+1];
  msfc_pkg::side_t side_q [Steps+1];
  msfc_pkg::rem_t  den_q  [Steps+1];
  msfc_pkg::rem_t  rem_q  [Steps+1][msfc_pkg::Lanes];
  msfc_pkg::quo_t  low_q  [Steps+1][msfc_pkg::Lanes];
  msfc_pkg::quo_t  quo_q  [Steps+1][msfc_pkg::Lanes];
  logic            sat_q  [Steps+1][msfc_pkg::Lanes];

  // first stage: quotient overflow check on the upper numerator bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    den_q[0]  <= den_i;
  end

  for (genvar l = 0; l < msfc_pkg::Lanes; l++) begin : g_init
    always_ff @(posedge clk_i) begin
      rem_q[0][l] <= num_i[l][msfc_pkg::NumW-1:QuoW];
      sat_q[0][l] <= num_i[l][msfc_pkg::NumW-1:QuoW] >= den_i;
      low_q[0][l] <= num_i[l][QuoW-1:0];
      quo_q[0][l] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
      den_q[k]  <= den_q[k-1];
    end

    for (genvar l = 0; l < msfc_pkg::Lanes; l++) begin : g_lane
      logic [RemW:0] r2, diff;
      logic          ge;

      assign r2   = {rem_q[k-1][l], low_q[k-1][l][QuoW-1]};
      assign diff = r2 - {1'b0, den_q[k-1]};
      assign ge   = !diff[RemW];

      always_ff @(posedge clk_i) begin
        rem_q[k][l] <= ge ? diff[RemW-1:0] : r2[RemW-1:0];
        low_q[k][l] <= {low_q[k-1][l][QuoW-2:0], 1'b0};
        quo_q[k][l] <= {quo_q[k-1][l][QuoW-2:0], ge};
        sat_q[k][l] <= sat_q[k-1][l];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign side_o  = side_q[Steps];

  for (genvar l = 0; l < msfc_pkg::Lanes; l++) begin : g_out
    assign quo_o[l] = quo_q[Steps][l];
    assign sat_o[l] = sat_q[Steps][l];
  end

endmodule

`default_nettype wire

@@ rtl/msfc_back.sv @@
// back pipeline: saturation, sign, boundary value and result registers
`default_nettype none

module msfc_back (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  input  wire msfc_pkg::side_t                       side_i,
  input  wire msfc_pkg::quo_t [msfc_pkg::Lanes-1:0]  quo_i,
  input  wire logic [msfc_pkg::Lanes-1:0]            sat_i,
  output logic                                       result_valid_o,
  output logic [31:0]                                vic_o,
  output logic [31:0]                                vbc_o,
  output logic [31:0]                                gic_o,
  output logic [31:0]                                gbc_o,
  output logic [31:0]                                bv_o,
  output logic                                       unres_o
);

  // stage g: cap each quotient
  logic [31:0] cap [msfc_pkg::Lanes];
  logic [31:0] val [msfc_pkg::Lanes];

  assign cap[0] = msfc_pkg::SatPos;
  assign cap[1] = side_i.inflow ? msfc_pkg::SatNeg : msfc_pkg::SatPos;
  assign cap[2] = msfc_pkg::SatPos;
  assign cap[3] = msfc_pkg::SatPos;

  for (genvar l = 0; l < msfc_pkg::Lanes; l++) begin : g_cap
    assign val[l] = (sat_i[l] || (quo_i[l] > cap[l])) ? cap[l] : quo_i[l];
  end

  logic        g_valid_q, g_unres_q;
  logic [30:0] g_cc_q;
  logic [31:0] g_vic_q, g_vbc_q, g_gic_q, g_gbc_q;

  always_ff @(posedge clk_i) begin
    g_unres_q <= side_i.unres;
    g_cc_q    <= side_i.cell_conc;
    g_vic_q   <= side_i.unres ? 32'd0 : val[0];
    g_gic_q   <= side_i.unres ? 32'd0 : (side_i.inflow ? (32'd0 - val[1]) : val[1]);
    g_vbc_q   <= val[2];
    g_gbc_q   <= val[3];
  end

  // stage h: cell concentration times value internal coefficient
  logic        h_valid_q, h_unres_q;
  logic [61:0] h_prod_q;
  logic [31:0] h_vic_q, h_vbc_q, h_gic_q, h_gbc_q;

  always_ff @(posedge clk_i) begin
    h_unres_q <= g_unres_q;
    h_prod_q  <= 62'(g_cc_q) * 62'(g_vic_q);
    h_vic_q   <= g_vic_q;
    h_vbc_q   <= g_vbc_q;
    h_gic_q   <= g_gic_q;
    h_gbc_q   <= g_gbc_q;
  end

  // stage i: boundary value and result registers
  logic        res_valid_q, res_unres_q;
  logic [31:0] res_vic_q, res_vbc_q, res_gic_q, res_gbc_q, res_bv_q;
  logic [61:0] prod_sh;
  logic [39:0] bv_sum;

  assign prod_sh = h_prod_q >> msfc_pkg::FracBits;
  assign bv_sum  = 40'(prod_sh) + 40'(h_vbc_q);

  always_ff @(posedge clk_i) begin
    res_unres_q <= h_unres_q;
    res_vic_q   <= h_vic_q;
    res_vbc_q   <= h_vbc_q;
    res_gic_q   <= h_gic_q;
    res_gbc_q   <= h_gbc_q;
    res_bv_q    <= (bv_sum > 40'(msfc_pkg::SatPos)) ? msfc_pkg::SatPos : bv_sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q   <= 1'b0;
      h_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      g_valid_q   <= valid_i;
      h_valid_q   <= g_valid_q;
      res_valid_q <= h_valid_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign vic_o          = res_vic_q;
  assign vbc_o          = res_vbc_q;
  assign gic_o          = res_gic_q;
  assign gbc_o          = res_gbc_q;
  assign bv_o           = res_bv_q;
  assign unres_o        = res_unres_q;

endmodule

`default_nettype wire

@@ rtl/membrane_solute_face_coeffs.sv @@
// top level of the membrane solute face coefficient block
//
// one boundary face per transfer: pulse start with the five face fields;
// busy stays low, so a new face may be taken in every cycle.
// configuration registers are written over the cfg channel (cfg_valid_i,
// cfg_ready_o, cfg_index_i, cfg_data_i); ready is always high and writes
// belong to idle periods, with no face in flight.
// each face gives one result: result_valid_o is high for exactly one cycle
// with the four coefficients, the boundary value and the unresolved flag.
// the result is registered through the front, divider and back stages and comes
// out in input order; throughput is one face per cycle.
// the pipeline is made of the 32 stage restoring divider (one quotient bit per
// stage, four lanes sharing the divisor), six front stages for products and
// diffusivity, one overflow check stage and three back stages for saturation
// and the boundary value.
// the receiver cannot stall; there is no backpressure anywhere.
// reset clears all valid bits and loads the register reset values
// (rejection one, diff_coeff one, diff_min and diff_conc_coeff zero).
`default_nettype none

module membrane_solute_face_coeffs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] normal_velocity_i,
  input  wire logic [30:0]        cell_spacing_i,
  input  wire logic [30:0]        face_conc_i,
  input  wire logic [30:0]        opposite_conc_i,
  input  wire logic [30:0]        cell_conc_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      value_internal_coeff_o,
  output logic signed [31:0]      value_boundary_coeff_o,
  output logic signed [31:0]      grad_internal_coeff_o,
  output logic signed [31:0]      grad_boundary_coeff_o,
  output logic signed [31:0]      boundary_value_o,
  output logic                    unresolved_o
);

  msfc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rejection       <= msfc_pkg::OneQ;
      cfg_q.diff_min        <= '0;
      cfg_q.diff_coeff      <= 31'(msfc_pkg::OneQ);
      cfg_q.diff_conc_coeff <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (msfc_pkg::cfg_reg_e'(cfg_index_i))
        msfc_pkg::RegRejection:     cfg_q.rejection       <= cfg_data_i[24:0];
        msfc_pkg::RegDiffMin:       cfg_q.diff_min        <= cfg_data_i[30:0];
        msfc_pkg::RegDiffCoeff:     cfg_q.diff_coeff      <= cfg_data_i[30:0];
        msfc_pkg::RegDiffConcCoeff: cfg_q.diff_conc_coeff <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  logic                                  front_valid;
  msfc_pkg::side_t                       front_side;
  msfc_pkg::rem_t                        front_den;
  msfc_pkg::num_t [msfc_pkg::Lanes-1:0]  front_num;

  msfc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .valid_i           (start && !busy),
    .normal_velocity_i (normal_velocity_i),
    .cell_spacing_i    (cell_spacing_i),
    .face_conc_i       (face_conc_i),
    .opposite_conc_i   (opposite_conc_i),
    .cell_conc_i       (cell_conc_i),
    .valid_o           (front_valid),
    .side_o            (front_side),
    .den_o             (front_den),
    .num_o             (front_num)
  );

  logic                                  div_valid;
  msfc_pkg::side_t                       div_side;
  msfc_pkg::quo_t [msfc_pkg::Lanes-1:0]  div_quo;
  logic [msfc_pkg::Lanes-1:0]            div_sat;

  msfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .side_i  (front_side),
    .den_i   (front_den),
    .num_i   (front_num),
    .valid_o (div_valid),
    .side_o  (div_side),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  logic [31:0] vic, vbc, gic, gbc, bv;

  msfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (div_valid),
    .side_i         (div_side),
    .quo_i          (div_quo),
    .sat_i          (div_sat),
    .result_valid_o (result_valid_o),
    .vic_o          (vic),
    .vbc_o          (vbc),
    .gic_o          (gic),
    .gbc_o          (gbc),
    .bv_o           (bv),
    .unres_o        (unresolved_o)
  );

  assign value_internal_coeff_o = $signed(vic);
  assign value_boundary_coeff_o = $signed(vbc);
  assign grad_internal_coeff_o  = $signed(gic);
  assign grad_boundary_coeff_o  = $signed(gbc);
  assign boundary_value_o       = $signed(bv);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench of the membrane solute face coefficient block
`default_nettype none

module testbench;

  typedef struct packed {
    logic signed [31:0] vel;
    logic [30:0]        spacing;
    logic [30:0]        face_c;
    logic [30:0]        opp_c;
    logic [30:0]        cell_c;
  } face_t;

  typedef struct packed {
    logic [31:0] vic;
    logic [31:0] vbc;
    logic [31:0] gic;
    logic [31:0] gbc;
    logic [31:0] bval;
    logic        unres;
  } coeffs_t;

  typedef struct packed {
    face_t   face;
    logic    typed;
    coeffs_t want;
  } face_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] normal_velocity_i = '0;
  logic [30:0] cell_spacing_i = '0;
  logic [30:0] face_conc_i = '0;
  logic [30:0] opposite_conc_i = '0;
  logic [30:0] cell_conc_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  msfc_pkg::cfg_reg_e cfg_index_i = msfc_pkg::RegRejection;
  logic [31:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [31:0] value_internal_coeff_o, value_boundary_coeff_o;
  logic signed [31:0] grad_internal_coeff_o, grad_boundary_coeff_o, boundary_value_o;
  logic unresolved_o;

  membrane_solute_face_coeffs u_top (
    .clk_i, .rst_ni, .start, .busy,
    .normal_velocity_i, .cell_spacing_i, .face_conc_i, .opposite_conc_i, .cell_conc_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .value_internal_coeff_o, .value_boundary_coeff_o,
    .grad_internal_coeff_o, .grad_boundary_coeff_o, .boundary_value_o, .unresolved_o
  );

  logic [24:0]        rejection_q = 25'h100_0000;
  logic [30:0]        diff_min_q = '0;
  logic [30:0]        diff_coeff_q = 31'h100_0000;
  logic signed [31:0] diff_conc_q = '0;

  coeffs_t pending_coeffs[$];
  coeffs_t typed_coeffs[$];
  logic    typed_flags[$];
  logic    next_typed = 1'b0;
  coeffs_t next_want;
  int      fail_cnt = 0;
  bit      idle_on = 1'b1;

  localparam coeffs_t NoWant = '0;
  localparam face_row_t DirRows[14] = '{
    '{'{32'sd0, 31'd1, 31'd0, 31'd0, 31'd0}, 1'b1,
      '{32'h0100_0000, 32'd0, 32'd1, 32'd0, 32'd0, 1'b0}},
    '{'{32'sh7fff_ffff, 31'h7fff_ffff, 31'd0, 31'd0, 31'd5}, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1}},
    '{'{32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff},
      1'b0, NoWant},
    '{'{-32'sd1, 31'd0, 31'd0, 31'h7fff_ffff, 31'h7fff_ffff}, 1'b0, NoWant},
    '{'{32'sd0, 31'd0, 31'h7fff_ffff, 31'd0, 31'h7fff_ffff}, 1'b0, NoWant},
    '{'{32'sd1, 31'h100_0000, 31'h100_0000, 31'h100_0000, 31'h100_0000}, 1'b0, NoWant},
    '{'{-32'sh100_0000, 31'h100_0000, 31'd0, 31'h100_0000, 31'h100_0000}, 1'b0, NoWant},
    '{'{32'sh80_0000, 31'h80_0000, 31'd0, 31'd0, 31'h7fff_ffff}, 1'b0, NoWant},
    '{'{32'sh100_0000, 31'h100_0000, 31'd0, 31'd0, 31'd0}, 1'b0, NoWant},
    '{'{32'sh0ff_ffff, 31'h100_0000, 31'd0, 31'd0, 31'h7fff_ffff}, 1'b0, NoWant},
    '{'{-32'sh7fff_ffff, 31'd1, 31'd1, 31'h7fff_ffff, 31'd1}, 1'b0, NoWant},
    '{'{-32'sd2, 31'h7fff_ffff, 31'h2aaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa}, 1'b0, NoWant},
    '{'{32'sh5555_5555, 31'h2aaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa, 31'h5555_5555},
      1'b0, NoWant},
    '{'{32'sh2aaa_aaaa, 31'h1, 31'h0, 31'h1, 31'h0}, 1'b0, NoWant}
  };

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] floor_div_cap(logic [127:0] num, logic [127:0] den,
                                                logic [63:0] cap);
    logic [127:0] q;
    q = num / den;
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] solute_diffusivity(logic [30:0] conc);
    logic signed [63:0] slope, cv, mc, fl, t;
    logic [127:0] p;
    slope = diff_conc_q;
    cv = {33'd0, conc};
    mc = slope * cv;
    fl = mc >>> msfc_pkg::FracBits;
    t = 64'sd16777216 - fl;
    if (t <= 0) return {33'd0, diff_min_q};
    p = ({97'd0, diff_coeff_q} * {64'd0, t}) >> msfc_pkg::FracBits;
    if (p > 128'h7fff_ffff) p = 128'h7fff_ffff;
    return (p[63:0] > {33'd0, diff_min_q}) ? p[63:0] : {33'd0, diff_min_q};
  endfunction

  function automatic coeffs_t face_coeffs(face_t f);
    coeffs_t c;
    logic [63:0] mag, delta, rej, dval, dq, ur, den, s, kf, vic, vbc, gbc, gmag, bv;
    logic [127:0] bsum;
    c = '0;
    vic = 0; vbc = 0; gbc = 0;
    mag = f.vel[31] ? (64'h1_0000_0000 - {32'd0, f.vel}) : {32'd0, f.vel};
    if (mag == 0) mag = 1;
    delta = (f.spacing == 0) ? 64'd1 : {33'd0, f.spacing};
    rej = (rejection_q < msfc_pkg::OneQ) ? {39'd0, rejection_q} : {39'd0, msfc_pkg::OneQ};
    dval = solute_diffusivity(f.face_c);
    dq = dval << msfc_pkg::FracBits;
    if (!f.vel[31]) begin
      ur = (mag * rej) >> msfc_pkg::FracBits;
      if ({64'd0, ur} * {64'd0, delta} >= {64'd0, dq}) begin
        c.unres = 1'b1;
      end else begin
        den = dq - ur * delta;
        vic = floor_div_cap({64'd0, dq} << msfc_pkg::FracBits, {64'd0, den}, 64'h7fff_ffff);
        c.gic = 32'(floor_div_cap({64'd0, ur} << (2 * msfc_pkg::FracBits), {64'd0, den},
                                  64'h7fff_ffff));
      end
    end else begin
      s = mag * delta;
      den = dq + s;
      kf = (({39'd0, msfc_pkg::OneQ} - rej) * {33'd0, f.opp_c}) >> msfc_pkg::FracBits;
      vic = floor_div_cap({64'd0, dq} << msfc_pkg::FracBits, {64'd0, den}, 64'h7fff_ffff);
      gmag = floor_div_cap({64'd0, mag} << (2 * msfc_pkg::FracBits), {64'd0, den},
                           64'h8000_0000);
      c.gic = 32'(-gmag);
      vbc = floor_div_cap({64'd0, kf} * {64'd0, s}, {64'd0, den}, 64'h7fff_ffff);
      gbc = floor_div_cap({64'd0, kf} * ({64'd0, mag} << msfc_pkg::FracBits), {64'd0, den},
                          64'h7fff_ffff);
    end
    bsum = (({97'd0, f.cell_c} * {64'd0, vic}) >> msfc_pkg::FracBits) + {64'd0, vbc};
    bv = (bsum > 128'h7fff_ffff) ? 64'h7fff_ffff : bsum[63:0];
    c.vic = vic[31:0];
    c.vbc = vbc[31:0];
    c.gbc = gbc[31:0];
    c.bval = bv[31:0];
    return c;
  endfunction

  // register writes and face transfers update the model at the same edge
  always @(posedge clk_i) begin
    coeffs_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_coeffs.size() == 0) begin
        $error("result with no face pending");
        fail_cnt++;
      end else begin
        w = pending_coeffs.pop_front();
        if (value_internal_coeff_o !== w.vic) begin
          $error("value_internal_coeff exp %h got %h", w.vic, value_internal_coeff_o);
          fail_cnt++;
        end
        if (value_boundary_coeff_o !== w.vbc) begin
          $error("value_boundary_coeff exp %h got %h", w.vbc, value_boundary_coeff_o);
          fail_cnt++;
        end
        if (grad_internal_coeff_o !== w.gic) begin
          $error("grad_internal_coeff exp %h got %h", w.gic, grad_internal_coeff_o);
          fail_cnt++;
        end
        if (grad_boundary_coeff_o !== w.gbc) begin
          $error("grad_boundary_coeff exp %h got %h", w.gbc, grad_boundary_coeff_o);
          fail_cnt++;
        end
        if (boundary_value_o !== w.bval) begin
          $error("boundary_value exp %h got %h", w.bval, boundary_value_o);
          fail_cnt++;
        end
        if (unresolved_o !== w.unres) begin
          $error("unresolved exp %b got %b", w.unres, unresolved_o);
          fail_cnt++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      w = face_coeffs({normal_velocity_i, cell_spacing_i, face_conc_i,
                       opposite_conc_i, cell_conc_i});
      if (next_typed && w !== next_want) begin
        $error("typed row disagrees with model exp %h got %h", next_want, w);
        fail_cnt++;
      end
      pending_coeffs.push_back(next_typed ? next_want : w);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msfc_pkg::RegRejection:     rejection_q = cfg_data_i[24:0];
        msfc_pkg::RegDiffMin:       diff_min_q = cfg_data_i[30:0];
        msfc_pkg::RegDiffCoeff:     diff_coeff_q = cfg_data_i[30:0];
        msfc_pkg::RegDiffConcCoeff: diff_conc_q = cfg_data_i;
        default: ;
      endcase
    end
  end

  task automatic send_face(face_t f, logic typed, coeffs_t want);
    while (idle_on && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    normal_velocity_i <= f.vel;
    cell_spacing_i <= f.spacing;
    face_conc_i <= f.face_c;
    opposite_conc_i <= f.opp_c;
    cell_conc_i <= f.cell_c;
    next_typed <= typed;
    next_want <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_faces();
    start <= 1'b0;
    next_typed <= 1'b0;
    @(posedge clk_i);
    while (pending_coeffs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(msfc_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field(int small_max);
    return ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, small_max));
  endfunction

  function automatic face_t rand_face();
    face_t f;
    logic [31:0] v;
    v = rand_field(32'h200_0000);
    f.vel = ($urandom_range(0, 1) != 0) ? -$signed(v) : $signed(v);
    f.spacing = 31'(rand_field(32'h100_0000));
    f.face_c = 31'(rand_field(32'h100_0000));
    f.opp_c = 31'(rand_field(32'h400_0000));
    f.cell_c = 31'(rand_field(32'h400_0000));
    return f;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirRows[i]) send_face(DirRows[i].face, DirRows[i].typed, DirRows[i].want);
    for (int ph = 0; ph < 6; ph++) begin
      drain_faces();
      case (ph)
        0: begin
          write_reg(msfc_pkg::RegRejection, 32'd0);
          write_reg(msfc_pkg::RegDiffCoeff, 32'h7fff_ffff);
          idle_on = 1'b0;
        end
        1: begin
          write_reg(msfc_pkg::RegRejection, 32'h1ff_ffff);
          write_reg(msfc_pkg::RegDiffMin, 32'h7fff_ffff);
          write_reg(msfc_pkg::RegDiffCoeff, 32'd0);
          idle_on = 1'b1;
        end
        2: begin
          write_reg(msfc_pkg::RegDiffMin, 32'd0);
          write_reg(msfc_pkg::RegDiffCoeff, 32'h100_0000);
          write_reg(msfc_pkg::RegDiffConcCoeff, 32'h7fff_ffff);
        end
        3: begin
          write_reg(msfc_pkg::RegDiffMin, 32'h10_0000);
          write_reg(msfc_pkg::RegDiffConcCoeff, 32'h8000_0000);
        end
        default: begin
          write_reg(msfc_pkg::RegRejection, 32'($urandom_range(0, 32'h100_0000)));
          write_reg(msfc_pkg::RegDiffMin, 32'($urandom_range(0, 32'h80_0000)));
          write_reg(msfc_pkg::RegDiffCoeff, 32'($urandom_range(1, 32'h400_0000)));
          write_reg(msfc_pkg::RegDiffConcCoeff,
                    32'($signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000));
        end
      endcase
      repeat (108) send_face(rand_face(), 1'b0, NoWant);
    end
    drain_faces();
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
